FILE: rtl/core/dq_pkg.sv
// Package for the bounded deque: sizes, operation and status codes,
// controller states and the structs passed between the core modules.
// No dependencies.
package dq_pkg;

	localparam int DEPTH   = 64;                // entries in the ring store, 2..64
	localparam int ADDR_W  = $clog2(DEPTH);     // ring index width
	localparam int CNT_W   = ADDR_W + 1;        // holds 0..DEPTH
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 7;                 // width of the count port

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_CLEAR      = 3'd4,
		OP_DUMP_FWD   = 3'd5,
		OP_DUMP_REV   = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RESP,
		ST_DUMP
	} state_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [DATA_W-1:0] wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

	typedef struct packed {
		status_t                   status;
		logic                      has_data;
		logic signed [DATA_W-1:0]  data;
		logic                      last;
		logic [COUNT_W-1:0]        count;
	} result_t;

	// Ring position base + off, with base < DEPTH and off <= DEPTH.
	function automatic logic [ADDR_W-1:0] ring_pos(input logic [ADDR_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [CNT_W-1:0] sum;
		sum = {1'b0, base} + off;
		if (sum >= CNT_W'(DEPTH)) begin
			sum = sum - CNT_W'(DEPTH);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage

FILE: rtl/core/dq_store.sv
// Ring entry store: one write port, one read port, registered read data.
// Depends on dq_pkg.
module dq_store (
	input  logic                     clk,
	input  dq_pkg::mem_req_t         req,
	output logic [dq_pkg::DATA_W-1:0] rd_data
);

	logic [dq_pkg::DATA_W-1:0] entry_mem [dq_pkg::DEPTH];
	logic [dq_pkg::DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			entry_mem[req.wr_addr] <= req.wr_data;
		end
	end

	// read data holds until the next read, so a stalled result keeps its value
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= entry_mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/dq_ctrl.sv
// Deque controller: front/count registers, request decode, store access
// and the dump walk. Depends on dq_pkg.
module dq_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  dq_pkg::op_t                      op,
	input  logic signed [dq_pkg::DATA_W-1:0] value,
	output dq_pkg::mem_req_t                 mem_req,
	input  logic [dq_pkg::DATA_W-1:0]        rd_data,
	output logic                             emit_valid,
	output dq_pkg::result_t                  emit,
	input  logic                             slot_free
);

	dq_pkg::state_t                state_q, state_d;
	logic [dq_pkg::ADDR_W-1:0]     front_q, front_d;
	logic [dq_pkg::CNT_W-1:0]      cnt_q, cnt_d;
	logic [dq_pkg::CNT_W-1:0]      idx_q, idx_d;
	logic                          rev_q, rev_d;
	dq_pkg::status_t               stat_q, stat_d;
	logic                          hasd_q, hasd_d;

	logic [dq_pkg::CNT_W-1:0]      idx_next;
	logic [dq_pkg::CNT_W-1:0]      dump_base;
	logic [dq_pkg::CNT_W-1:0]      dump_off;
	logic                          rev_sel;
	logic                          dump_last;
	logic                          full;
	logic                          empty;

	assign idx_next  = idx_q + dq_pkg::CNT_W'(1);
	assign dump_base = (state_q == dq_pkg::ST_IDLE) ? '0 : idx_next;
	assign rev_sel   = (state_q == dq_pkg::ST_IDLE) ? (op == dq_pkg::OP_DUMP_REV) : rev_q;
	assign dump_off  = rev_sel ? (cnt_q - dq_pkg::CNT_W'(1) - dump_base) : dump_base;
	assign dump_last = (idx_next == cnt_q);
	assign full      = (cnt_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));
	assign empty     = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dq_pkg::ST_IDLE;
			front_q <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
			rev_q   <= 1'b0;
			stat_q  <= dq_pkg::STAT_OK;
			hasd_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			rev_q   <= rev_d;
			stat_q  <= stat_d;
			hasd_q  <= hasd_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		front_d    = front_q;
		cnt_d      = cnt_q;
		idx_d      = idx_q;
		rev_d      = rev_q;
		stat_d     = stat_q;
		hasd_d     = hasd_q;
		in_ready   = 1'b0;
		mem_req    = '0;
		emit_valid = 1'b0;
		emit       = '0;

		case (state_q)
			dq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					stat_d  = dq_pkg::STAT_OK;
					hasd_d  = 1'b0;
					state_d = dq_pkg::ST_RESP;
					case (op)
						dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
							if (full) begin
								stat_d = dq_pkg::STAT_FULL;
							end else begin
								mem_req.wr_en   = 1'b1;
								mem_req.wr_data = value;
								if (op == dq_pkg::OP_PUSH_FRONT) begin
									front_d         = dq_pkg::ring_pos(front_q,
										dq_pkg::CNT_W'(dq_pkg::DEPTH - 1));
									mem_req.wr_addr = front_d;
								end else begin
									mem_req.wr_addr = dq_pkg::ring_pos(front_q, cnt_q);
								end
								cnt_d = cnt_q + dq_pkg::CNT_W'(1);
							end
						end
						dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
							if (empty) begin
								stat_d = dq_pkg::STAT_EMPTY;
							end else begin
								hasd_d        = 1'b1;
								mem_req.rd_en = 1'b1;
								if (op == dq_pkg::OP_POP_FRONT) begin
									mem_req.rd_addr = front_q;
									front_d = dq_pkg::ring_pos(front_q, dq_pkg::CNT_W'(1));
								end else begin
									mem_req.rd_addr = dq_pkg::ring_pos(front_q,
										cnt_q - dq_pkg::CNT_W'(1));
								end
								cnt_d = cnt_q - dq_pkg::CNT_W'(1);
							end
						end
						dq_pkg::OP_CLEAR: begin
							cnt_d   = '0;
							front_d = '0;
						end
						dq_pkg::OP_DUMP_FWD, dq_pkg::OP_DUMP_REV: begin
							if (empty) begin
								stat_d = dq_pkg::STAT_EMPTY;
							end else begin
								// fetch the first entry now, walk the rest in ST_DUMP
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = dq_pkg::ring_pos(front_q, dump_off);
								idx_d   = '0;
								rev_d   = rev_sel;
								state_d = dq_pkg::ST_DUMP;
							end
						end
						default: begin
						end
					endcase
				end
			end

			dq_pkg::ST_RESP: begin
				emit_valid    = 1'b1;
				emit.status   = stat_q;
				emit.has_data = hasd_q;
				emit.data     = hasd_q ? signed'(rd_data) : '0;
				emit.last     = 1'b1;
				emit.count    = dq_pkg::COUNT_W'(cnt_q);
				if (slot_free) begin
					state_d = dq_pkg::ST_IDLE;
				end
			end

			dq_pkg::ST_DUMP: begin
				emit_valid    = 1'b1;
				emit.status   = dq_pkg::STAT_OK;
				emit.has_data = 1'b1;
				emit.data     = signed'(rd_data);
				emit.last     = dump_last;
				emit.count    = dq_pkg::COUNT_W'(cnt_q);
				if (slot_free) begin
					if (dump_last) begin
						state_d = dq_pkg::ST_IDLE;
					end else begin
						mem_req.rd_en   = 1'b1;
						mem_req.rd_addr = dq_pkg::ring_pos(front_q, dump_off);
						idx_d           = idx_next;
					end
				end
			end

			default: begin
				state_d = dq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/dq_outreg.sv
// Output register between the controller and the result channel.
// Depends on dq_pkg.
module dq_outreg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             emit_valid,
	input  dq_pkg::result_t                  emit,
	output logic                             slot_free,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       status,
	output logic                             has_data,
	output logic signed [dq_pkg::DATA_W-1:0] data,
	output logic                             last,
	output logic [dq_pkg::COUNT_W-1:0]       count
);

	logic            valid_q;
	dq_pkg::result_t res_q;

	assign slot_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit_valid && slot_free) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_valid && slot_free) begin
			res_q <= emit;
		end
	end

	assign out_valid = valid_q;
	assign status    = res_q.status;
	assign has_data  = res_q.has_data;
	assign data      = res_q.data;
	assign last      = res_q.last;
	assign count     = res_q.count;

endmodule

FILE: rtl/core/bounded_deque.sv
// Bounded double-ended queue of signed 32-bit words in a 64-entry ring.
// Request channel: in_valid/in_ready with operation and value. Result
// channel: out_valid/out_ready with status, has_data, data, last, count.
// Every request gives one result, except a dump of a non-empty queue,
// which gives one result per entry with last set on the final one.
// The first result of a request goes from the controller's response or
// dump state into the output register, after the store's registered
// read for a pop or dump; the controller handles one request at a time,
// so push, pop, clear and the unused code each finish before the next.
// A dump of N entries returns N results, one per cycle while the
// receiver keeps out_ready high; no request is taken until it ends.
// The next request is taken while the last result still waits in the
// output register. When the receiver stalls, the result holds and the
// controller waits; the queue state does not change meanwhile.
// Reset empties the queue (front and count go to zero) at once; the
// store itself is not cleared, since only live entries are read.
// Depends on dq_pkg, dq_store, dq_ctrl, dq_outreg.
module bounded_deque (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [2:0]                       operation,
	input  logic signed [dq_pkg::DATA_W-1:0] value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       status,
	output logic                             has_data,
	output logic signed [dq_pkg::DATA_W-1:0] data,
	output logic                             last,
	output logic [dq_pkg::COUNT_W-1:0]       count
);

	dq_pkg::mem_req_t          mem_req;
	logic [dq_pkg::DATA_W-1:0] rd_data;
	logic                      emit_valid;
	dq_pkg::result_t           emit;
	logic                      slot_free;

	dq_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	dq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (dq_pkg::op_t'(operation)),
		.value      (value),
		.mem_req    (mem_req),
		.rd_data    (rd_data),
		.emit_valid (emit_valid),
		.emit       (emit),
		.slot_free  (slot_free)
	);

	dq_outreg u_outreg (
		.clk        (clk),
		.arst_n     (arst_n),
		.emit_valid (emit_valid),
		.emit       (emit),
		.slot_free  (slot_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.has_data   (has_data),
		.data       (data),
		.last       (last),
		.count      (count)
	);

endmodule

FILE: rtl/core/bounded_deque_chk.sv
// Port-level checker for bounded_deque, attached by bind.
// Depends on dq_pkg.
module bounded_deque_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic [2:0]                       operation,
	input logic signed [dq_pkg::DATA_W-1:0] value,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [1:0]                       status,
	input logic                             has_data,
	input logic signed [dq_pkg::DATA_W-1:0] data,
	input logic                             last,
	input logic [dq_pkg::COUNT_W-1:0]       count
);

	// a stalled result transaction keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data) && $stable(status)
			&& $stable(last) && $stable(count))
		else $error("result changed while stalled");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count <= dq_pkg::COUNT_W'(dq_pkg::DEPTH))
		else $error("count above depth");

	a_no_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_data |-> data == '0 && last)
		else $error("result without data has nonzero data or is not last");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == dq_pkg::STAT_FULL |->
			count == dq_pkg::COUNT_W'(dq_pkg::DEPTH) && !has_data)
		else $error("full status with count below depth");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == dq_pkg::STAT_EMPTY |-> count == '0 && !has_data)
		else $error("empty status with entries held");

endmodule

bind bounded_deque bounded_deque_chk u_chk (.*);

FILE: dv/tb_top.sv
// Testbench for bounded_deque: a directed table followed by weighted random
// traffic, each result checked against typed values or a bench deque predictor.
// Depends on dq_pkg and the bounded_deque RTL.
`timescale 1ns / 100ps

module tb_top;
	import dq_pkg::*;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int N_DIRECTED = 20;
	localparam int N_RANDOM = 330;

	typedef enum int {TRAFFIC_FILL, TRAFFIC_DRAIN, TRAFFIC_ANY} traffic_t;
	typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_t;

	typedef struct {
		logic [2:0]         op;
		logic signed [31:0] val;
		bit                 typed;
		result_t            res;
	} stim_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [2:0]                 operation = OP_PUSH_FRONT;
	logic signed [DATA_W-1:0]   value = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [1:0]                 status;
	logic                       has_data;
	logic signed [DATA_W-1:0]   data;
	logic                       last;
	logic [COUNT_W-1:0]         count;

	bounded_deque uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Deque predictor: ring of words, front position and fill level
	logic signed [DATA_W-1:0] ring_words [DEPTH];
	logic [ADDR_W-1:0]        head_pos = '0;
	logic [CNT_W-1:0]         fill_cnt = '0;
	result_t                  expected_results [$];
	int                       mismatch_count = 0;
	int                       burst_left = 0;

	// Expected values typed in where they follow directly from the queue contents
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{OP_POP_FRONT,  32'sd0,           1, '{STAT_EMPTY, 1'b0, 32'sd0, 1'b1, 7'd0}},
		'{OP_POP_BACK,   32'sd0,           1, '{STAT_EMPTY, 1'b0, 32'sd0, 1'b1, 7'd0}},
		'{OP_DUMP_FWD,   32'sd0,           1, '{STAT_EMPTY, 1'b0, 32'sd0, 1'b1, 7'd0}},
		'{OP_DUMP_REV,   32'sd0,           1, '{STAT_EMPTY, 1'b0, 32'sd0, 1'b1, 7'd0}},
		'{OP_PUSH_BACK,  32'sh7FFFFFFF,    1, '{STAT_OK, 1'b0, 32'sd0, 1'b1, 7'd1}},
		'{OP_PUSH_FRONT, 32'sh80000000,    1, '{STAT_OK, 1'b0, 32'sd0, 1'b1, 7'd2}},
		'{OP_PUSH_BACK,  32'sd0,           1, '{STAT_OK, 1'b0, 32'sd0, 1'b1, 7'd3}},
		'{OP_PUSH_FRONT, -32'sd1,          1, '{STAT_OK, 1'b0, 32'sd0, 1'b1, 7'd4}},
		'{OP_DUMP_FWD,   32'sd0,           0, '0},
		'{OP_DUMP_REV,   32'sd0,           0, '0},
		'{OP_POP_FRONT,  32'sd0,           1, '{STAT_OK, 1'b1, -32'sd1, 1'b1, 7'd3}},
		'{OP_POP_BACK,   32'sd0,           1, '{STAT_OK, 1'b1, 32'sd0, 1'b1, 7'd2}},
		'{OP_UNUSED,     32'sh5555AAAA,    1, '{STAT_OK, 1'b0, 32'sd0, 1'b1, 7'd2}},
		'{OP_PUSH_BACK,  32'sh12345678,    0, '0},
		'{OP_DUMP_REV,   32'sd0,           0, '0},
		'{OP_CLEAR,      32'sh7FFFFFFF,    1, '{STAT_OK, 1'b0, 32'sd0, 1'b1, 7'd0}},
		'{OP_DUMP_FWD,   32'sd0,           1, '{STAT_EMPTY, 1'b0, 32'sd0, 1'b1, 7'd0}},
		'{OP_PUSH_FRONT, 32'shA5A5A5A5,    0, '0},
		'{OP_POP_BACK,   32'sd0,           0, '0},
		'{OP_POP_FRONT,  32'sd0,           1, '{STAT_EMPTY, 1'b0, 32'sd0, 1'b1, 7'd0}}
	};

	function automatic logic [ADDR_W-1:0] ring_slot(input int off);
		return ADDR_W'((int'(head_pos) + off) % DEPTH);
	endfunction

	function automatic void queue_result(input status_t st, input logic hd,
			input logic signed [DATA_W-1:0] d, input logic lst);
		result_t r;
		r.status   = st;
		r.has_data = hd;
		r.data     = d;
		r.last     = lst;
		r.count    = COUNT_W'(fill_cnt);
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic void deque_apply(input logic [2:0] op,
			input logic signed [DATA_W-1:0] v);
		int k;
		int off;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (fill_cnt >= DEPTH) begin
					queue_result(STAT_FULL, 1'b0, '0, 1'b1);
				end else begin
					if (op == OP_PUSH_FRONT) begin
						head_pos = ring_slot(DEPTH - 1);
						ring_words[head_pos] = v;
					end else begin
						ring_words[ring_slot(int'(fill_cnt))] = v;
					end
					fill_cnt++;
					queue_result(STAT_OK, 1'b0, '0, 1'b1);
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (fill_cnt == 0) begin
					queue_result(STAT_EMPTY, 1'b0, '0, 1'b1);
				end else if (op == OP_POP_FRONT) begin
					fill_cnt--;
					queue_result(STAT_OK, 1'b1, ring_words[head_pos], 1'b1);
					head_pos = ring_slot(1);
				end else begin
					fill_cnt--;
					queue_result(STAT_OK, 1'b1, ring_words[ring_slot(int'(fill_cnt))], 1'b1);
				end
			end
			OP_CLEAR: begin
				fill_cnt = '0;
				head_pos = '0;
				queue_result(STAT_OK, 1'b0, '0, 1'b1);
			end
			OP_DUMP_FWD, OP_DUMP_REV: begin
				if (fill_cnt == 0) begin
					queue_result(STAT_EMPTY, 1'b0, '0, 1'b1);
				end else begin
					for (k = 0; k < int'(fill_cnt); k++) begin
						off = (op == OP_DUMP_FWD) ? k : int'(fill_cnt) - 1 - k;
						queue_result(STAT_OK, 1'b1, ring_words[ring_slot(off)],
							k + 1 == int'(fill_cnt));
					end
				end
			end
			default: begin
				queue_result(STAT_OK, 1'b0, '0, 1'b1);
			end
		endcase
	endfunction

	// Weights are indexed by operation code
	function automatic logic [2:0] pick_op(input traffic_t mode);
		int w [8];
		int total;
		int r;
		int k;
		case (mode)
			TRAFFIC_FILL:  w = '{35, 35, 6, 6, 1, 4, 4, 2};
			TRAFFIC_DRAIN: w = '{8, 8, 35, 35, 1, 5, 5, 3};
			default:       w = '{18, 18, 18, 18, 3, 9, 9, 7};
		endcase
		total = 0;
		for (k = 0; k < 8; k++) begin
			total += w[k];
		end
		r = $urandom_range(0, total - 1);
		for (k = 0; k < 8; k++) begin
			if (r < w[k]) begin
				return 3'(k);
			end
			r -= w[k];
		end
		return OP_UNUSED;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 11))
			0:       return 32'sh7FFFFFFF;
			1:       return 32'sh80000000;
			2:       return 32'sd0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Bursts of back-to-back transactions separated by random idle gaps
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic send_item(input logic [2:0] op, input logic signed [DATA_W-1:0] v);
		pace_sender();
		in_valid  <= 1'b1;
		operation <= op;
		value     <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		deque_apply(op, v);
	endtask

	task automatic drain_wait();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic report_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Result checker and receiver stall pattern
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       rx_phase = 0;

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual status=%0d data=%0d",
					$time, status, data);
				mismatch_count++;
			end else begin
				want = expected_results[0];
				expected_results.delete(0);
				report_field("status", want.status, status);
				report_field("has_data", want.has_data, has_data);
				report_field("data", want.data, data);
				report_field("last", want.last, last);
				report_field("count", want.count, count);
			end
		end
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		rx_phase = (rx_phase + 1) % 3;
		case (rx_mode)
			RX_OPEN:  out_ready <= 1'b1;
			RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY: out_ready <= ($urandom_range(0, 9) < 3);
			default:  out_ready <= (rx_phase != 0);
		endcase
	end

	initial begin
		int i;
		int random_done;
		int seg_len;
		traffic_t mode;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_DIRECTED; i++) begin
			send_item(directed_rows[i].op, directed_rows[i].val);
			if (directed_rows[i].typed) begin
				expected_results[expected_results.size() - 1] = directed_rows[i].res;
			end
		end
		drain_wait();

		// Fill to the brim, push into a full queue, dump it both ways
		random_done = 0;
		while (fill_cnt < DEPTH) begin
			send_item($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
			random_done++;
		end
		for (i = 0; i < 4; i++) begin
			send_item($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
			random_done++;
		end
		send_item(OP_DUMP_FWD, pick_value());
		send_item(OP_DUMP_REV, pick_value());
		random_done += 2;

		while (random_done < N_RANDOM) begin
			mode = traffic_t'($urandom_range(0, 2));
			seg_len = $urandom_range(10, 50);
			if ($urandom_range(0, 2) == 0) begin
				drain_wait();
			end
			for (i = 0; i < seg_len && random_done < N_RANDOM; i++) begin
				send_item(pick_op(mode), pick_value());
				random_done++;
			end
		end

		drain_wait();
		repeat (12) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/dq_pkg.sv
rtl/core/dq_store.sv
rtl/core/dq_ctrl.sv
rtl/core/dq_outreg.sv
rtl/core/bounded_deque.sv
rtl/core/bounded_deque_chk.sv
dv/tb_top.sv
